[hw/rtl/sfd_pkg.sv]
// sfd_pkg: shared types, width-mode codes and helpers for the signed floor divider
// depends on nothing; imported by signed_floor_divider
package sfd_pkg;

  // operand width and number of quotient-bit stages
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAGES = DATA_W;

  // element width codes
  localparam logic [1:0] WMODE_8     = 2'd0;
  localparam logic [1:0] WMODE_16    = 2'd1;
  localparam logic [1:0] WMODE_32    = 2'd2;
  localparam logic [1:0] WMODE_RESET = WMODE_32;

  typedef logic [DATA_W-1:0] word_t;

  // per-item control that travels down the pipeline with the data
  typedef struct packed {
    logic       neg;
    logic       dz;
    logic       ovf;
    logic       eoa;
    logic [1:0] mode;
  } sfd_ctl_t;

  // sign-extend the low bits of a word at the selected element width
  function automatic word_t sext_mode(input word_t v, input logic [1:0] mode);
    word_t r;
    case (mode)
      WMODE_8:  r = {{(DATA_W-8){v[7]}}, v[7:0]};
      WMODE_16: r = {{(DATA_W-16){v[15]}}, v[15:0]};
      default:  r = v;
    endcase
    return r;
  endfunction

  // most negative value of the selected width, sign-extended
  function automatic word_t min_mode(input logic [1:0] mode);
    word_t r;
    case (mode)
      WMODE_8:  r = {{(DATA_W-7){1'b1}}, 7'd0};
      WMODE_16: r = {{(DATA_W-15){1'b1}}, 15'd0};
      default:  r = {1'b1, {(DATA_W-1){1'b0}}};
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/signed_floor_divider.sv]
// signed_floor_divider: pipelined signed floor division at 8, 16 or 32-bit width
// 34 register stages; one item per cycle while the pipeline is not stalled
// one restoring-division stage per quotient bit (32 stages) plus an operand stage
// and a floor/sign-extend output stage; the whole pipeline stalls while a result waits
// with out_ready low
// reset (rst_n, synchronous, active low) empties the pipeline and sets 32-bit mode
// depends on sfd_pkg
module signed_floor_divider
  import sfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_dividend,
  input  logic signed [31:0] in_divisor,
  input  logic               in_end_of_array,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_quotient,
  output logic               out_divide_by_zero,
  output logic               out_overflow_flag,
  output logic               out_end_of_array_out
);

  logic [1:0] mode_r;
  logic       adv;

  // pipeline registers, index 0 is the operand stage
  logic       vld_r [0:STAGES];
  word_t      dq_r  [0:STAGES];
  word_t      rem_r [0:STAGES];
  word_t      dvs_r [0:STAGES];
  sfd_ctl_t   ctl_r [0:STAGES];

  // per-stage next values
  logic [DATA_W:0] shifted [1:STAGES];
  logic [DATA_W:0] diff    [1:STAGES];
  word_t           dq_nxt  [1:STAGES];
  word_t           rem_nxt [1:STAGES];

  // operand stage signals
  word_t    a_ext, b_ext, a_mag, b_mag;
  sfd_ctl_t ctl_nxt;

  // output stage signals
  word_t q_mag, q_raw, q_nxt;
  logic  rem_nz;

  logic               out_valid_r;
  logic signed [31:0] out_quotient_r;
  logic               out_dz_r, out_ovf_r, out_eoa_r;

  // whole pipeline moves when the output register is free or being taken
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // width mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= WMODE_RESET;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // operand stage: sign-extend, magnitudes, special cases
  always_comb begin
    a_ext = sext_mode(word_t'(in_dividend), mode_r);
    b_ext = sext_mode(word_t'(in_divisor), mode_r);
    a_mag = a_ext[DATA_W-1] ? (~a_ext + word_t'(1)) : a_ext;
    b_mag = b_ext[DATA_W-1] ? (~b_ext + word_t'(1)) : b_ext;
    ctl_nxt.neg  = a_ext[DATA_W-1] ^ b_ext[DATA_W-1];
    ctl_nxt.dz   = (b_ext == '0);
    ctl_nxt.ovf  = (a_ext == min_mode(mode_r)) && (b_ext == '1);
    ctl_nxt.eoa  = in_end_of_array;
    ctl_nxt.mode = mode_r;
  end

  // one quotient bit per stage, msb first
  always_comb begin
    for (int k = 1; k <= STAGES; k++) begin
      shifted[k] = {rem_r[k-1], dq_r[k-1][DATA_W-1]};
      diff[k]    = shifted[k] - {1'b0, dvs_r[k-1]};
      rem_nxt[k] = diff[k][DATA_W] ? shifted[k][DATA_W-1:0] : diff[k][DATA_W-1:0];
      dq_nxt[k]  = {dq_r[k-1][DATA_W-2:0], !diff[k][DATA_W]};
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= STAGES; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      dq_r[0]  <= a_mag;
      rem_r[0] <= '0;
      dvs_r[0] <= b_mag;
      ctl_r[0] <= ctl_nxt;
      for (int k = 1; k <= STAGES; k++) begin
        dq_r[k]  <= dq_nxt[k];
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_r[k-1];
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // output stage: apply sign with floor rounding, then special cases
  always_comb begin
    q_mag  = dq_r[STAGES];
    rem_nz = |rem_r[STAGES];
    if (ctl_r[STAGES].neg) begin
      // -q - 1 when inexact, -q when exact
      q_raw = rem_nz ? ~q_mag : (~q_mag + word_t'(1));
    end else begin
      q_raw = q_mag;
    end
    if (ctl_r[STAGES].dz) begin
      q_nxt = '0;
    end else if (ctl_r[STAGES].ovf) begin
      q_nxt = min_mode(ctl_r[STAGES].mode);
    end else begin
      q_nxt = sext_mode(q_raw, ctl_r[STAGES].mode);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_quotient_r <= q_nxt;
      out_dz_r       <= ctl_r[STAGES].dz;
      out_ovf_r      <= ctl_r[STAGES].ovf && !ctl_r[STAGES].dz;
      out_eoa_r      <= ctl_r[STAGES].eoa;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_quotient         = out_quotient_r;
  assign out_divide_by_zero   = out_dz_r;
  assign out_overflow_flag    = out_ovf_r;
  assign out_end_of_array_out = out_eoa_r;

endmodule
